[rtl/core/etot_pkg.sv]
// Shared types and constants of the extended tick one-shot timer.
package etot_pkg;

	// Full-scale value of the hardware down-counter
	localparam int unsigned COUNTER_MAX = 65535;

	localparam int unsigned TICK_W = 64;
	localparam int unsigned CNT_W  = 16;

	// One full counter period, in ticks
	localparam logic [TICK_W-1:0] PERIOD     = TICK_W'(COUNTER_MAX) + TICK_W'(1);
	localparam logic [TICK_W-1:0] LIMIT      = TICK_W'(COUNTER_MAX);
	localparam logic [CNT_W-1:0]  RELOAD_MAX = CNT_W'(COUNTER_MAX);

	// Request opcodes
	typedef enum logic [2:0] {
		OP_WRAP    = 3'd0,
		OP_ARM     = 3'd1,
		OP_READ    = 3'd2,
		OP_SET     = 3'd3,
		OP_ENABLE  = 3'd4,
		OP_DISABLE = 3'd5
	} op_t;

endpackage

[rtl/core/extended_tick_oneshot_timer_unit.sv]
// Extended 64-bit tick count and one-shot deadline on a 16-bit down-counter.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------------
//   in      | in_valid/in_ready  | opcode, counter_now, operand_value
//   out     | out_valid/out_ready| tick_count, expired, reload_write, reload_value
//
// Each request passes through the input register and then the result
// register; one request per cycle is sustained while out_ready is high.
// The tick base, ticks left and last reload update in the same cycle that the
// request moves into the result register, so a following request sees them.
// A stalled result holds the input register; in_ready drops only when both
// registers are full and out_ready is low. Reset clears all timer state.
module extended_tick_oneshot_timer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [15:0] counter_now,
	input  logic [63:0] operand_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] tick_count,
	output logic        expired,
	output logic        reload_write,
	output logic [15:0] reload_value
);

	// Input stage
	logic        valid_s1;
	logic [2:0]  opcode_s1;
	logic [15:0] counter_s1;
	logic [63:0] operand_s1;

	// Timer state
	logic [63:0] base_ticks_q;
	logic [63:0] ticks_left_q;
	logic [15:0] last_reload_q;

	// Result register
	logic        out_valid_q;
	logic [63:0] tick_count_q;
	logic        expired_q;
	logic        reload_write_q;
	logic [15:0] reload_value_q;

	logic advance;

	// Next-state and result values
	logic [63:0] elapsed;
	logic [63:0] now_ticks;
	logic [63:0] next_left;
	logic [63:0] left_dec;
	logic [63:0] base_plus_left;
	logic [63:0] base_plus_period;
	logic [63:0] base_nx;
	logic [63:0] left_nx;
	logic [15:0] reload_nx;
	logic [63:0] tc_nx;
	logic        exp_nx;
	logic        wr_nx;
	logic [15:0] rv_nx;

	// Signed compare against the counter limit
	function automatic logic below_limit(input logic [63:0] v);
		below_limit = v[63] || (v < etot_pkg::LIMIT);
	endfunction

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Capture an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1  <= opcode;
			counter_s1 <= counter_now;
			operand_s1 <= operand_value;
		end
	end

	// Ticks since the last reload, wrapping once through a full period
	always_comb begin
		if (counter_s1 <= last_reload_q) begin
			elapsed = 64'(last_reload_q) - 64'(counter_s1);
		end else begin
			elapsed = etot_pkg::PERIOD + 64'(last_reload_q) - 64'(counter_s1);
		end
	end

	assign now_ticks        = base_ticks_q + elapsed;
	assign next_left        = operand_s1 - now_ticks;
	assign left_dec         = ticks_left_q - etot_pkg::PERIOD;
	assign base_plus_left   = base_ticks_q + ticks_left_q;
	assign base_plus_period = base_ticks_q + etot_pkg::PERIOD;

	// Decode the request against the current state
	always_comb begin
		base_nx   = base_ticks_q;
		left_nx   = ticks_left_q;
		reload_nx = last_reload_q;
		tc_nx     = base_ticks_q;
		exp_nx    = 1'b0;
		wr_nx     = 1'b0;
		rv_nx     = '0;
		case (etot_pkg::op_t'(opcode_s1))
			etot_pkg::OP_WRAP: begin
				reload_nx = etot_pkg::RELOAD_MAX;
				if (ticks_left_q == '0) begin
					base_nx = base_plus_period;
				end else if (below_limit(ticks_left_q)) begin
					// deadline reached within this period
					base_nx = base_plus_left;
					left_nx = '0;
					exp_nx  = 1'b1;
				end else begin
					left_nx = left_dec;
					base_nx = base_plus_period;
					if (below_limit(left_dec)) begin
						reload_nx = left_dec[15:0];
					end
				end
				wr_nx = 1'b1;
				rv_nx = reload_nx;
				tc_nx = base_nx;
			end
			etot_pkg::OP_ARM: begin
				tc_nx = now_ticks;
				if (next_left[63]) begin
					exp_nx = 1'b1;
				end else begin
					if (next_left < etot_pkg::LIMIT) begin
						base_nx   = now_ticks;
						reload_nx = next_left[15:0];
						wr_nx     = 1'b1;
						rv_nx     = next_left[15:0];
					end
					left_nx = next_left;
				end
			end
			etot_pkg::OP_READ: begin
				tc_nx = now_ticks;
			end
			etot_pkg::OP_SET: begin
				base_nx = operand_s1;
				tc_nx   = operand_s1;
			end
			etot_pkg::OP_ENABLE: begin
				left_nx   = '0;
				base_nx   = base_ticks_q + 64'(counter_s1);
				reload_nx = etot_pkg::RELOAD_MAX;
				wr_nx     = 1'b1;
				rv_nx     = etot_pkg::RELOAD_MAX;
				tc_nx     = base_nx;
			end
			etot_pkg::OP_DISABLE: begin
				// stop the counter, keep the last reload
				wr_nx = 1'b1;
			end
			default: begin
				tc_nx = base_ticks_q;
			end
		endcase
	end

	// Advance the timer state with each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_ticks_q  <= '0;
			ticks_left_q  <= '0;
			last_reload_q <= '0;
		end else if (advance) begin
			base_ticks_q  <= base_nx;
			ticks_left_q  <= left_nx;
			last_reload_q <= reload_nx;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tick_count_q   <= tc_nx;
			expired_q      <= exp_nx;
			reload_write_q <= wr_nx;
			reload_value_q <= rv_nx;
		end
	end

	assign out_valid    = out_valid_q;
	assign tick_count   = tick_count_q;
	assign expired      = expired_q;
	assign reload_write = reload_write_q;
	assign reload_value = reload_value_q;

endmodule

[rtl/core/etot_checker.sv]
// Port-level checks for the extended tick one-shot timer, bound to the top level.
module etot_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] tick_count,
	input logic        expired,
	input logic        reload_write,
	input logic [15:0] reload_value
);

	// Hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tick_count)
			&& $stable(reload_value) && $stable(expired) && $stable(reload_write))
		else $error("stalled result changed");

	// Drive zero reload when no reload is requested
	a_reload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reload_write |-> reload_value == '0)
		else $error("reload value without reload write");

	// Expiry on a wrap always reloads full scale
	a_expire_reload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired && reload_write |-> reload_value == etot_pkg::RELOAD_MAX)
		else $error("expiry reload not full scale");

	// Accept requests whenever the result register is empty
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind extended_tick_oneshot_timer_unit etot_checker u_etot_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.tick_count   (tick_count),
	.expired      (expired),
	.reload_write (reload_write),
	.reload_value (reload_value)
);
